// ===== design/gmlc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmlc_pkg
// Shared types and constants of the gate motor limit controller.
// ----------------------------------------------------------------------------
package gmlc_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_OPEN  = 2'd1,
		OP_CLOSE = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		MOT_IDLE      = 3'd0,
		MOT_OPENING   = 3'd1,
		MOT_CLOSING   = 3'd2,
		MOT_IS_OPEN   = 3'd3,
		MOT_IS_CLOSED = 3'd4
	} motion_t;

	typedef enum logic [1:0] {
		ERR_NONE        = 2'd0,
		ERR_OVERCURRENT = 2'd1,
		ERR_TIMEOUT     = 2'd2
	} error_t;

	typedef enum logic [1:0] {
		RPL_ACCEPT = 2'd0,
		RPL_BUSY   = 2'd1,
		RPL_ERROR  = 2'd2
	} reply_t;

	typedef enum logic [1:0] {
		REG_OPEN_LEVEL  = 2'd0,
		REG_CLOSE_LEVEL = 2'd1,
		REG_OC_LEVEL    = 2'd2,
		REG_START_POWER = 2'd3
	} reg_index_t;

	localparam int unsigned TICK_W  = 32;
	localparam int unsigned DUTY_W  = 16;
	localparam int unsigned EVENT_W = 4;

	localparam logic [DUTY_W-1:0] START_POWER_RESET = 16'd4000;
	localparam logic [TICK_W-1:0] TICKS_MAX         = '1;

	localparam int unsigned EV_OVERCURRENT = 0;
	localparam int unsigned EV_OPENED      = 1;
	localparam int unsigned EV_CLOSED      = 2;
	localparam int unsigned EV_TIMEOUT     = 3;

	// Result of one beat, before packing.
	typedef struct packed {
		logic                 fwd;
		logic                 bwd;
		logic [DUTY_W-1:0]    duty;
		motion_t              motion;
		error_t               err;
		logic [EVENT_W-1:0]   events;
		logic [2:0]           sensors;
		reply_t               reply;
	} result_t;

endpackage
`default_nettype wire

// ===== design/gate_motor_limit_controller_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gate_motor_limit_controller_core
// Sliding gate motor control: limit switches, overcurrent cut, move timeout.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Contents
//  s_axis    in         s_tvalid / s_tready        tuser: op; tdata: pins, tick limit
//  m_axis    out        m_tvalid / m_tready        tdata: drives, duty, state, flags
//  cfg       in         cfg_we (no wait)           cfg_index, cfg_data
//
//  Each beat passes through the input register, then the state update and result
//  are computed in one pass and land in the result register. A new beat can be
//  accepted every cycle while the result register is not held by m_tready low.
//  arst_n clears the gate state and restores the default active levels (high) and
//  start power. When the result register is held by m_tready low, the input
//  register keeps one more beat and s_tready drops only once both are full.
//
`default_nettype none
module gate_motor_limit_controller_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// tdata, from bit 0: open_pin_level, close_pin_level, overcurrent_pin_level,
	// move_timeout_ticks[31:0], zero fill to 40 bits.
	input  wire logic [39:0] s_tdata,
	// tuser, from bit 0: op[1:0].
	input  wire logic [1:0]  s_tuser,
	// Result stream.
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// tdata, from bit 0: forward_drive_on, backward_drive_on, drive_duty[15:0],
	// motion_state[2:0], error_code[1:0], event_flags[3:0], sensor_bits[2:0],
	// reply[1:0].
	output      logic [31:0] m_tdata,
	// Configuration writes.
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned TW = gmlc_pkg::TICK_W;
	localparam int unsigned DW = gmlc_pkg::DUTY_W;

	// Configuration registers.
	logic          open_lvl_q;
	logic          close_lvl_q;
	logic          oc_lvl_q;
	logic [DW-1:0] start_power_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_lvl_q    <= 1'b1;
			close_lvl_q   <= 1'b1;
			oc_lvl_q      <= 1'b1;
			start_power_q <= gmlc_pkg::START_POWER_RESET;
		end else if (cfg_we) begin
			case (gmlc_pkg::reg_index_t'(cfg_index))
				gmlc_pkg::REG_OPEN_LEVEL:  open_lvl_q    <= cfg_data[0];
				gmlc_pkg::REG_CLOSE_LEVEL: close_lvl_q   <= cfg_data[0];
				gmlc_pkg::REG_OC_LEVEL:    oc_lvl_q      <= cfg_data[0];
				gmlc_pkg::REG_START_POWER: start_power_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register stage.
	logic                 valid_s1;
	gmlc_pkg::op_t        op_s1;
	logic                 open_pin_s1;
	logic                 close_pin_s1;
	logic                 oc_pin_s1;
	logic [TW-1:0]        limit_s1;
	logic                 advance;

	// Result register stage.
	logic                 valid_s2;
	gmlc_pkg::result_t    res_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1        <= gmlc_pkg::op_t'(s_tuser);
			open_pin_s1  <= s_tdata[0];
			close_pin_s1 <= s_tdata[1];
			oc_pin_s1    <= s_tdata[2];
			limit_s1     <= s_tdata[34:3];
		end
	end

	// Gate state.
	logic                 fwd_q;
	logic                 bwd_q;
	logic [DW-1:0]        duty_q;
	gmlc_pkg::motion_t    motion_q;
	gmlc_pkg::error_t     err_q;
	logic [TW-1:0]        ticks_q;
	logic [TW-1:0]        limit_q;
	logic                 open_sent_q;
	logic                 close_sent_q;

	// Next state of one beat.
	logic                 fwd_d;
	logic                 bwd_d;
	logic [DW-1:0]        duty_d;
	gmlc_pkg::motion_t    motion_d;
	gmlc_pkg::error_t     err_d;
	logic [TW-1:0]        ticks_d;
	logic [TW-1:0]        limit_d;
	logic                 open_sent_d;
	logic                 close_sent_d;
	logic [3:0]           events;
	gmlc_pkg::reply_t     reply;
	logic                 s_open;
	logic                 s_close;
	logic                 s_oc;
	gmlc_pkg::result_t    res_d;

	// Pin levels are qualified against their configured active levels.
	assign s_open  = (open_pin_s1 == open_lvl_q);
	assign s_close = (close_pin_s1 == close_lvl_q);
	assign s_oc    = (oc_pin_s1 == oc_lvl_q);

	always_comb begin
		fwd_d        = fwd_q;
		bwd_d        = bwd_q;
		duty_d       = duty_q;
		motion_d     = motion_q;
		err_d        = err_q;
		ticks_d      = ticks_q;
		limit_d      = limit_q;
		open_sent_d  = open_sent_q;
		close_sent_d = close_sent_q;
		events       = '0;
		reply        = gmlc_pkg::RPL_ACCEPT;

		unique case (op_s1)
			gmlc_pkg::OP_TICK: begin
				// Overcurrent cuts the drives but leaves the motion state, so
				// the move counter keeps running toward its timeout.
				if (s_oc) begin
					fwd_d = 1'b0;
					bwd_d = 1'b0;
					if (err_q != gmlc_pkg::ERR_OVERCURRENT) begin
						err_d = gmlc_pkg::ERR_OVERCURRENT;
						events[gmlc_pkg::EV_OVERCURRENT] = 1'b1;
					end
				end
				if (fwd_d) begin
					motion_d = gmlc_pkg::MOT_OPENING;
				end else if (bwd_d) begin
					motion_d = gmlc_pkg::MOT_CLOSING;
				end
				// The open limit wins when both limits read active.
				if (s_open) begin
					fwd_d    = 1'b0;
					motion_d = gmlc_pkg::MOT_IS_OPEN;
					if (!open_sent_q) begin
						open_sent_d = 1'b1;
						events[gmlc_pkg::EV_OPENED] = 1'b1;
					end
				end else if (s_close) begin
					bwd_d    = 1'b0;
					motion_d = gmlc_pkg::MOT_IS_CLOSED;
					if (!close_sent_q) begin
						close_sent_d = 1'b1;
						events[gmlc_pkg::EV_CLOSED] = 1'b1;
					end
				end
				if (motion_d == gmlc_pkg::MOT_OPENING ||
				    motion_d == gmlc_pkg::MOT_CLOSING) begin
					if (ticks_q != gmlc_pkg::TICKS_MAX) begin
						ticks_d = ticks_q + TW'(1);
					end
					// Timeout ends the move and goes idle, so it fires once.
					if (ticks_d >= limit_q) begin
						fwd_d    = 1'b0;
						bwd_d    = 1'b0;
						err_d    = gmlc_pkg::ERR_TIMEOUT;
						motion_d = gmlc_pkg::MOT_IDLE;
						events[gmlc_pkg::EV_TIMEOUT] = 1'b1;
					end
				end
			end
			gmlc_pkg::OP_OPEN, gmlc_pkg::OP_CLOSE: begin
				if (s_oc) begin
					reply = gmlc_pkg::RPL_ERROR;
				end else if ((op_s1 == gmlc_pkg::OP_OPEN) ? s_open : s_close) begin
					reply = gmlc_pkg::RPL_ACCEPT;
				end else begin
					err_d   = gmlc_pkg::ERR_NONE;
					ticks_d = '0;
					limit_d = limit_s1;
					duty_d  = start_power_q;
					if (op_s1 == gmlc_pkg::OP_OPEN) begin
						fwd_d       = 1'b1;
						bwd_d       = 1'b0;
						open_sent_d = 1'b0;
						motion_d    = gmlc_pkg::MOT_OPENING;
						reply       = gmlc_pkg::RPL_ACCEPT;
					end else begin
						fwd_d        = 1'b0;
						bwd_d        = 1'b1;
						close_sent_d = 1'b0;
						motion_d     = gmlc_pkg::MOT_CLOSING;
						reply        = gmlc_pkg::RPL_BUSY;
					end
				end
			end
			gmlc_pkg::OP_STOP: begin
				fwd_d    = 1'b0;
				bwd_d    = 1'b0;
				err_d    = gmlc_pkg::ERR_NONE;
				motion_d = gmlc_pkg::MOT_IDLE;
			end
			default: ;
		endcase

		res_d.fwd     = fwd_d;
		res_d.bwd     = bwd_d;
		res_d.duty    = (fwd_d || bwd_d) ? duty_d : '0;
		res_d.motion  = motion_d;
		res_d.err     = err_d;
		res_d.events  = events;
		res_d.sensors = {s_oc, s_close, s_open};
		res_d.reply   = reply;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q        <= 1'b0;
			bwd_q        <= 1'b0;
			duty_q       <= '0;
			motion_q     <= gmlc_pkg::MOT_IDLE;
			err_q        <= gmlc_pkg::ERR_NONE;
			ticks_q      <= '0;
			limit_q      <= '0;
			open_sent_q  <= 1'b0;
			close_sent_q <= 1'b0;
		end else if (advance) begin
			fwd_q        <= fwd_d;
			bwd_q        <= bwd_d;
			duty_q       <= duty_d;
			motion_q     <= motion_d;
			err_q        <= err_d;
			ticks_q      <= ticks_d;
			limit_q      <= limit_d;
			open_sent_q  <= open_sent_d;
			close_sent_q <= close_sent_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.reply, res_s2.sensors, res_s2.events, res_s2.err,
	                   res_s2.motion, res_s2.duty, res_s2.bwd, res_s2.fwd};

`ifndef SYNTHESIS
	// Only one drive direction is ever enabled.
	a_one_drive: assert property (@(posedge clk) disable iff (!arst_n)
		!(fwd_q && bwd_q))
		else $error("forward and backward drives both enabled");

	// The forward drive runs only during an opening move; a close limit met on
	// the way shows the gate as closed while the forward drive stays on.
	a_fwd_opening: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> (motion_q == gmlc_pkg::MOT_OPENING ||
		           motion_q == gmlc_pkg::MOT_IS_CLOSED))
		else $error("forward drive on outside an opening move");

	// A reported timeout leaves the gate idle with the timeout error latched.
	a_timeout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.events[gmlc_pkg::EV_TIMEOUT]) |->
		(res_s2.motion == gmlc_pkg::MOT_IDLE && res_s2.err == gmlc_pkg::ERR_TIMEOUT &&
		 !res_s2.fwd && !res_s2.bwd))
		else $error("timeout event without idle state and timeout error");

	// An opened event always reports the gate as open.
	a_opened_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.events[gmlc_pkg::EV_OPENED]) |->
		(res_s2.motion == gmlc_pkg::MOT_IS_OPEN))
		else $error("opened event with wrong motion state");
`endif

endmodule
`default_nettype wire
